### hdl/ffps_pkg.sv
// shared types and constants for the flow field particle step unit
package ffps_pkg;

	// cell index width, wide enough for grids up to 1024 on a side
	localparam int CELL_W = 11;

	// register reset and fixed point constants
	localparam logic [30:0] MAX_SPEED_RST = 31'd1073742;
	localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;

	// iteration counts of the square root and divide chains
	localparam int SQ_STEPS = 32;
	localparam int DIV_STEPS = 32;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// input word
	typedef struct packed {
		logic op;
		logic [6:0] cell_col;
		logic [5:0] cell_row;
		logic signed [31:0] field_x;
		logic signed [31:0] field_y;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
	} in_word_t;

	// output word
	typedef struct packed {
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] prev_x;
		logic signed [31:0] prev_y;
		logic wrapped;
	} out_word_t;

	// per particle context carried down the pipeline
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [32:0] vx;
		logic signed [32:0] vy;
		logic [32:0] ax;
		logic [32:0] ay;
		logic big;
		logic scale;
	} ctx_t;

endpackage

### hdl/flow_field_particle_step_unit.sv
// flow field particle step unit: field grid memory and particle step pipeline
//
// Input channel in_valid/in_ready/in_data carries one word per handshake.
// A write word (op 0) stores a flow vector into the grid memory and gives
// no result; a step word (op 1) looks up the cell under the position, adds
// the vector to the velocity, limits the speed to max_speed, moves and
// wraps the position, and gives one word on out_valid/out_ready/out_data.
// The max_speed register is to be loaded through cfg_we/cfg_wdata only
// while idle, a rule for the user the block does not enforce. Throughput
// is one word per cycle unless the output stalls. A step word passes cell
// lookup, a registered memory read, squaring, a 32 stage square root, a
// multiply and a 32 stage restoring divide pipeline (one result bit per
// stage), then the wrap stage. The whole pipeline advances only when the
// output register is empty or being taken, so a stalled receiver holds
// every word in place and drops in_ready; nothing is lost. Reset clears
// all valid bits and loads max_speed with its default. Grid cells hold no
// reset value and must be written before a step word reads them.
module flow_field_particle_step_unit
	import ffps_pkg::*;
#(
	parameter int GRID_COLS = 128,
	parameter int GRID_ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata
);

	localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int AW = CW + RW;
	localparam int DEPTH = 1 << AW;

	logic en;
	logic out_valid_q;
	out_word_t out_data_q;

	// config register and its square
	logic [30:0] max_speed_q;
	logic [61:0] max_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= MAX_SPEED_RST;
		end else if (cfg_we) begin
			max_speed_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		max_sq_q <= 62'(max_speed_q) * 62'(max_speed_q);
	end

	// pipeline advance
	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	// stage 0: offset position and scale to cell units
	logic signed [32:0] tx, ty;
	assign tx = {in_data.pos_x[31], in_data.pos_x} + ONE_Q30;
	assign ty = {in_data.pos_y[31], in_data.pos_y} + ONE_Q30;

	logic v_s1;
	in_word_t d_s1;
	logic tx_le_s1, ty_le_s1;
	logic [42:0] prodx_s1, prody_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= in_data;
			tx_le_s1 <= tx[32] || (tx == 33'sd0);
			ty_le_s1 <= ty[32] || (ty == 33'sd0);
			prodx_s1 <= 43'(tx[31:0]) * 43'(GRID_COLS);
			prody_s1 <= 43'(ty[31:0]) * 43'(GRID_ROWS);
		end
	end

	// stage 1: clamp cell, memory access
	logic [11:0] cx, cy, col, row;
	logic [CELL_W-1:0] wcol, wrow;
	logic wr_ok;
	logic [AW-1:0] raddr, waddr;

	assign cx = prodx_s1[42:31];
	assign cy = prody_s1[42:31];
	assign col = tx_le_s1 ? 12'd0 :
		((cx >= 12'(GRID_COLS)) ? 12'(GRID_COLS - 1) : cx);
	assign row = ty_le_s1 ? 12'd0 :
		((cy >= 12'(GRID_ROWS)) ? 12'(GRID_ROWS - 1) : cy);
	assign raddr = {row[RW-1:0], col[CW-1:0]};
	assign wcol = CELL_W'(d_s1.cell_col);
	assign wrow = CELL_W'(d_s1.cell_row);
	assign wr_ok = (wcol < CELL_W'(GRID_COLS)) && (wrow < CELL_W'(GRID_ROWS));
	assign waddr = {wrow[RW-1:0], wcol[CW-1:0]};

	logic [63:0] field_mem [DEPTH];
	logic [63:0] rd_s2;

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			if (d_s1.op == OP_WRITE) begin
				if (wr_ok) begin
					field_mem[waddr] <= {d_s1.field_y, d_s1.field_x};
				end
			end else begin
				rd_s2 <= field_mem[raddr];
			end
		end
	end

	logic v_s2;
	logic signed [31:0] px_s2, py_s2, velx_s2, vely_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && (d_s1.op == OP_STEP);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= d_s1.pos_x;
			py_s2 <= d_s1.pos_y;
			velx_s2 <= d_s1.vel_x;
			vely_s2 <= d_s1.vel_y;
		end
	end

	// stage 2: add field vector
	logic v_s3;
	logic signed [32:0] vx_s3, vy_s3;
	logic signed [31:0] px_s3, py_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s3 <= {velx_s2[31], velx_s2} + {rd_s2[31], rd_s2[31:0]};
			vy_s3 <= {vely_s2[31], vely_s2} + {rd_s2[63], rd_s2[63:32]};
			px_s3 <= px_s2;
			py_s3 <= py_s2;
		end
	end

	// stage 3: magnitudes, pre-shift of large vectors
	logic [32:0] ax3, ay3;
	logic big3;
	assign ax3 = vx_s3[32] ? 33'(-vx_s3) : 33'(vx_s3);
	assign ay3 = vy_s3[32] ? 33'(-vy_s3) : 33'(vy_s3);
	assign big3 = ax3[32] || ax3[31] || ay3[32] || ay3[31];

	logic v_s4;
	ctx_t ctx_s4;
	logic [30:0] sx_s4, sy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4.px <= px_s3;
			ctx_s4.py <= py_s3;
			ctx_s4.vx <= vx_s3;
			ctx_s4.vy <= vy_s3;
			ctx_s4.ax <= ax3;
			ctx_s4.ay <= ay3;
			ctx_s4.big <= big3;
			ctx_s4.scale <= 1'b0;
			sx_s4 <= big3 ? ax3[32:2] : ax3[30:0];
			sy_s4 <= big3 ? ay3[32:2] : ay3[30:0];
		end
	end

	// stage 4: squares
	logic v_s5;
	ctx_t ctx_s5;
	logic [61:0] sqx_s5, sqy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s5 <= ctx_s4;
			sqx_s5 <= 62'(sx_s4) * 62'(sx_s4);
			sqy_s5 <= 62'(sy_s4) * 62'(sy_s4);
		end
	end

	// stage 5: sum of squares, speed limit test
	logic [62:0] rad5;
	ctx_t ctx5_sc;
	assign rad5 = 63'(sqx_s5) + 63'(sqy_s5);

	always_comb begin
		ctx5_sc = ctx_s5;
		ctx5_sc.scale = ctx_s5.big || (rad5 > 63'(max_sq_q));
	end

	logic sq_v_s [SQ_STEPS+1];
	logic [63:0] sq_rem_s [SQ_STEPS+1];
	logic [63:0] sq_root_s [SQ_STEPS+1];
	ctx_t sq_ctx_s [SQ_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem_s[0] <= 64'(rad5);
			sq_root_s[0] <= 64'd0;
			sq_ctx_s[0] <= ctx5_sc;
		end
	end

	// square root, one result bit per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		logic ge;
		assign trial = sq_root_s[k] + SQ_BIT;
		assign ge = sq_rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_ctx_s[k+1] <= sq_ctx_s[k];
				if (ge) begin
					sq_rem_s[k+1] <= sq_rem_s[k] - trial;
					sq_root_s[k+1] <= (sq_root_s[k] >> 1) + SQ_BIT;
				end else begin
					sq_rem_s[k+1] <= sq_rem_s[k];
					sq_root_s[k+1] <= sq_root_s[k] >> 1;
				end
			end
		end
	end

	// magnitude and scaled numerators
	logic [31:0] root;
	logic [33:0] mag;
	ctx_t sq_ctx_end;
	assign root = sq_root_s[SQ_STEPS][31:0];
	assign sq_ctx_end = sq_ctx_s[SQ_STEPS];
	assign mag = sq_ctx_end.big ? {root, 2'b00} : {2'b00, root};

	logic dv_v_s [DIV_STEPS+1];
	logic [63:0] dv_remx_s [DIV_STEPS+1];
	logic [63:0] dv_remy_s [DIV_STEPS+1];
	logic [31:0] dv_qx_s [DIV_STEPS+1];
	logic [31:0] dv_qy_s [DIV_STEPS+1];
	logic [33:0] dv_den_s [DIV_STEPS+1];
	ctx_t dv_ctx_s [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_remx_s[0] <= 64'(sq_ctx_end.ax) * 64'(max_speed_q);
			dv_remy_s[0] <= 64'(sq_ctx_end.ay) * 64'(max_speed_q);
			dv_qx_s[0] <= 32'd0;
			dv_qy_s[0] <= 32'd0;
			dv_den_s[0] <= mag;
			dv_ctx_s[0] <= sq_ctx_end;
		end
	end

	// restoring divide, one quotient bit per stage for both components
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int SH = DIV_STEPS - 1 - j;
		logic [65:0] dsh, trx, try_;
		assign dsh = 66'(dv_den_s[j]) << SH;
		assign trx = 66'(dv_remx_s[j]) - dsh;
		assign try_ = 66'(dv_remy_s[j]) - dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_den_s[j+1] <= dv_den_s[j];
				dv_ctx_s[j+1] <= dv_ctx_s[j];
				dv_remx_s[j+1] <= trx[65] ? dv_remx_s[j] : trx[63:0];
				dv_remy_s[j+1] <= try_[65] ? dv_remy_s[j] : try_[63:0];
				dv_qx_s[j+1] <= dv_qx_s[j] | (32'(!trx[65]) << SH);
				dv_qy_s[j+1] <= dv_qy_s[j] | (32'(!try_[65]) << SH);
			end
		end
	end

	// sign, saturate, select scaled or raw velocity
	ctx_t dv_ctx_end;
	logic signed [33:0] qsx, qsy;
	logic signed [31:0] satx, saty, nvx, nvy;
	assign dv_ctx_end = dv_ctx_s[DIV_STEPS];
	assign qsx = dv_ctx_end.vx[32] ? -$signed({2'b00, dv_qx_s[DIV_STEPS]})
		: $signed({2'b00, dv_qx_s[DIV_STEPS]});
	assign qsy = dv_ctx_end.vy[32] ? -$signed({2'b00, dv_qy_s[DIV_STEPS]})
		: $signed({2'b00, dv_qy_s[DIV_STEPS]});
	assign satx = (qsx > 34'sd2147483647) ? 32'sh7FFFFFFF :
		((qsx < -34'sd2147483648) ? 32'sh80000000 : qsx[31:0]);
	assign saty = (qsy > 34'sd2147483647) ? 32'sh7FFFFFFF :
		((qsy < -34'sd2147483648) ? 32'sh80000000 : qsy[31:0]);
	assign nvx = dv_ctx_end.scale ? satx : dv_ctx_end.vx[31:0];
	assign nvy = dv_ctx_end.scale ? saty : dv_ctx_end.vy[31:0];

	logic v_f;
	logic signed [31:0] nvx_f, nvy_f, px_f, py_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f <= 1'b0;
		end else if (en) begin
			v_f <= dv_v_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nvx_f <= nvx;
			nvy_f <= nvy;
			px_f <= dv_ctx_end.px;
			py_f <= dv_ctx_end.py;
		end
	end

	// move and wrap at the edges
	logic signed [32:0] mx, my;
	logic wx_pos, wx_neg, wy_pos, wy_neg, wrap_any;
	logic signed [31:0] nx, ny;
	assign mx = {px_f[31], px_f} + {nvx_f[31], nvx_f};
	assign my = {py_f[31], py_f} + {nvy_f[31], nvy_f};
	assign wx_pos = (mx > ONE_Q30) && (nvx_f > 32'sd0);
	assign wx_neg = (mx < -ONE_Q30) && (nvx_f < 32'sd0);
	assign wy_pos = (my > ONE_Q30) && (nvy_f > 32'sd0);
	assign wy_neg = (my < -ONE_Q30) && (nvy_f < 32'sd0);
	assign nx = wx_pos ? -32'sd1073741824 : (wx_neg ? 32'sd1073741824 : mx[31:0]);
	assign ny = wy_pos ? -32'sd1073741824 : (wy_neg ? 32'sd1073741824 : my[31:0]);
	assign wrap_any = wx_pos || wx_neg || wy_pos || wy_neg;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_f;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q.new_x <= nx;
			out_data_q.new_y <= ny;
			out_data_q.new_vel_x <= nvx_f;
			out_data_q.new_vel_y <= nvy_f;
			out_data_q.prev_x <= wrap_any ? nx : px_f;
			out_data_q.prev_y <= wrap_any ? ny : py_f;
			out_data_q.wrapped <= wrap_any;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule
